### hw/rtl/gwm_pkg.sv
// ----------------------------------------------------------------------------
// gwm_pkg
// Shared types and constants for the glob wildcard matcher cells.
// ----------------------------------------------------------------------------
package gwm_pkg;

    localparam int CHAR_W = 8;
    localparam int REG_W  = 64;
    localparam int LEN_W  = 5;
    localparam int IDX_W  = 2;
    localparam int STORED = 16;   // pattern bytes held in the two byte registers

    localparam logic [CHAR_W-1:0] CH_STAR  = 8'h2A;
    localparam logic [CHAR_W-1:0] CH_QUERY = 8'h3F;
    localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2E;

    localparam logic [IDX_W-1:0] REG_PAT_LOW  = 2'd0;
    localparam logic [IDX_W-1:0] REG_PAT_HIGH = 2'd1;
    localparam logic [IDX_W-1:0] REG_PAT_LEN  = 2'd2;

    // handed from one cell to the next every cycle
    typedef struct packed {
        logic adv;      // position advanced into the next cell
        logic carry;    // closure over a star at this position
    } gwm_link_t;

    // broadcast to all cells
    typedef struct packed {
        logic              load;     // rebuild the start set after a config write
        logic              step;     // consume ch
        logic              restart;  // end of string, back to the start set
        logic [CHAR_W-1:0] ch;
    } gwm_ctrl_t;

endpackage

### hw/rtl/gwm_cell.sv
// ----------------------------------------------------------------------------
// gwm_cell
// One pattern position: alive bit, start-set bit and the per-character update.
// ----------------------------------------------------------------------------
module gwm_cell
    import gwm_pkg::*;
#(
    parameter logic INIT = 1'b0
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [CHAR_W-1:0] pat_char,
    input  logic              active,
    input  gwm_ctrl_t         ctrl,
    input  gwm_link_t         link_in,
    output gwm_link_t         link_out,
    output logic              probe
);

    logic alive_reg;
    logic alive_next;
    logic start_reg;
    logic start_next;
    logic is_star;
    logic hit;
    logic live;
    logic raw;
    logic closed;

    assign is_star = active && (pat_char == CH_STAR);
    assign hit     = active && !is_star &&
                     ((pat_char == ctrl.ch) || ((pat_char == CH_QUERY) && (ctrl.ch != CH_DOT)));

    // during a start-set rebuild only the seed from cell 0 enters the chain
    assign live   = alive_reg && !ctrl.load;
    assign raw    = (live && is_star) || link_in.adv;
    assign closed = raw || link_in.carry;

    assign link_out.adv   = live && hit;
    assign link_out.carry = closed && is_star;

    assign probe = ctrl.step ? closed : alive_reg;

    always_comb
    begin
        alive_next = alive_reg;
        start_next = start_reg;
        if (ctrl.load)
        begin
            alive_next = closed;
            start_next = closed;
        end
        else if (ctrl.restart)
        begin
            alive_next = start_reg;
        end
        else if (ctrl.step)
        begin
            alive_next = closed;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alive_reg <= INIT;
            start_reg <= INIT;
        end
        else
        begin
            alive_reg <= alive_next;
            start_reg <= start_next;
        end
    end

endmodule

### hw/rtl/glob_wildcard_matcher.sv
// ----------------------------------------------------------------------------
// glob_wildcard_matcher
// Streams a subject string one byte per request and matches it against a
// configured glob pattern ('*' any run, '?' any byte but '.').
// ----------------------------------------------------------------------------
// The block takes one subject byte per clock cycle, back to back, unless
// s_tready drops (a result not yet taken or a start-set rebuild), and keeps
// a row of MAX_PATTERN+1 cells, one per pattern position, that hold the set
// of live positions; on each step every cell updates from its own byte and
// hands an advance bit and a star-closure bit to its neighbor. The closure
// ripples through the row like a carry chain, within a single step. The
// request with tlast set produces one result in m_tdata bit 0 in the next
// cycle, held until taken. A configuration write to one of the three registers
// restarts the string and blocks input for the following cycle while the
// start set of the new pattern is rebuilt; a register index of 3 is ignored.
module glob_wildcard_matcher
    import gwm_pkg::*;
#(
    parameter int MAX_PATTERN = 16
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [7:0]       s_tdata,     // char_code
    input  logic [0:0]       s_tuser,     // char_valid
    input  logic             s_tlast,     // end_of_string
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [7:0]       m_tdata,     // matched, zero padded
    input  logic             cfg_we,
    input  logic [IDX_W-1:0] cfg_index,
    input  logic [REG_W-1:0] cfg_data
);

    localparam int POS_W = $clog2(MAX_PATTERN + 1);
    localparam int CMP_W = 7;

    logic [REG_W-1:0]              pat_low_reg;
    logic [REG_W-1:0]              pat_high_reg;
    logic [LEN_W-1:0]              pat_len_reg;
    logic                          settle_reg;
    logic [POS_W-1:0]              eff_len_reg;
    logic                          out_valid_reg;
    logic                          matched_reg;

    logic [STORED-1:0][CHAR_W-1:0] pat_bytes;
    logic                          cfg_hit;
    logic                          accept;
    logic [CMP_W-1:0]              len_ext;
    logic [CMP_W-1:0]              eff_len;
    gwm_ctrl_t                     ctrl;
    gwm_link_t                     links [0:MAX_PATTERN];
    logic [MAX_PATTERN:0]          probes;

    assign pat_bytes = {pat_high_reg, pat_low_reg};

    assign cfg_hit = cfg_we && ((cfg_index == REG_PAT_LOW) || (cfg_index == REG_PAT_HIGH) ||
                                (cfg_index == REG_PAT_LEN));

    assign s_tready = !settle_reg && (!out_valid_reg || m_tready);
    assign accept   = s_tvalid && s_tready;

    assign ctrl.load    = settle_reg;
    assign ctrl.step    = accept && s_tuser[0];
    assign ctrl.restart = accept && s_tlast;
    assign ctrl.ch      = s_tdata;

    // cell 0 is seeded during a start-set rebuild
    assign links[0].adv   = settle_reg;
    assign links[0].carry = 1'b0;

    genvar p;
    generate
        for (p = 0; p <= MAX_PATTERN; p++)
        begin : g_cell
            logic [CHAR_W-1:0] cell_char;
            logic              cell_active;

            if (p < STORED)
            begin : g_stored
                assign cell_char = pat_bytes[p];
            end
            else
            begin : g_zero
                assign cell_char = '0;
            end

            if ((p < MAX_PATTERN) && (p < (1 << LEN_W)))
            begin : g_act
                assign cell_active = (pat_len_reg > LEN_W'(p));
            end
            else
            begin : g_idle
                assign cell_active = 1'b0;
            end

            if (p < MAX_PATTERN)
            begin : g_mid
                gwm_cell #(
                    .INIT ((p == 0) ? 1'b1 : 1'b0)
                ) u_cell (
                    .clk      (clk),
                    .rst_n    (rst_n),
                    .pat_char (cell_char),
                    .active   (cell_active),
                    .ctrl     (ctrl),
                    .link_in  (links[p]),
                    .link_out (links[p+1]),
                    .probe    (probes[p])
                );
            end
            else
            begin : g_last
                gwm_cell #(
                    .INIT ((p == 0) ? 1'b1 : 1'b0)
                ) u_cell (
                    .clk      (clk),
                    .rst_n    (rst_n),
                    .pat_char (cell_char),
                    .active   (cell_active),
                    .ctrl     (ctrl),
                    .link_in  (links[p]),
                    .link_out (),
                    .probe    (probes[p])
                );
            end
        end
    endgenerate

    assign len_ext = CMP_W'(pat_len_reg);
    assign eff_len = (len_ext > CMP_W'(MAX_PATTERN)) ? CMP_W'(MAX_PATTERN) : len_ext;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pat_low_reg  <= '0;
            pat_high_reg <= '0;
            pat_len_reg  <= '0;
            settle_reg   <= 1'b0;
            eff_len_reg  <= '0;
        end
        else
        begin
            settle_reg <= cfg_hit;
            if (settle_reg)
            begin
                eff_len_reg <= eff_len[POS_W-1:0];
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_PAT_LOW:  pat_low_reg  <= cfg_data;
                    REG_PAT_HIGH: pat_high_reg <= cfg_data;
                    REG_PAT_LEN:  pat_len_reg  <= cfg_data[LEN_W-1:0];
                    default:      ;
                endcase
            end
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctrl.restart)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.restart)
        begin
            matched_reg <= probes[eff_len_reg];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'b0, matched_reg};

endmodule
